>>> rtl/gmps_pkg.sv
`timescale 1ns / 1ps

package gmps_pkg;

    localparam int MAX_COLUMNS   = 512;
    localparam int BUDGET_LAYERS = 3;
    localparam int ROW_LIMIT     = 512;

    localparam int VAL_W     = 16;
    localparam int SUM_W     = 28;
    localparam int CNT_W     = 10;
    localparam int ROW_W     = 9;
    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    // wide enough for a column count and for a column position plus one
    localparam int CMP_W     = (((COL_W + 1) > CNT_W) ? (COL_W + 1) : CNT_W) + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

    // one line-store row: best sums of all budget layers for one column
    typedef logic [BUDGET_LAYERS-1:0][SUM_W-1:0] layer_vec_t;

endpackage

>>> rtl/grid_max_path_sum_with_skips_unit.sv
`timescale 1ns / 1ps

// best_total is registered: the top-left cell passes through stage 1, then the output register.
// Throughput: one cell per cycle while in_ready is high; the line store then reads and writes one row each cycle.
// in_ready drops only while a finished total waits and stage 1 holds the next grid's last cell.
// Reset (rst_n, async, low): counts to 1, positions and right-neighbor sums to 0,
// pipeline and output empty. The line store is not cleared; no clearing pass.
module grid_max_path_sum_with_skips_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gmps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmps_pkg::CNT_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [gmps_pkg::VAL_W-1:0]   cell_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gmps_pkg::SUM_W-1:0]   best_total
);
    import gmps_pkg::*;

    // configuration
    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] column_count_reg;

    // grid position of the next cell to arrive (counted from bottom-right)
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;
    logic [COL_W-1:0] col_pos_reg;
    logic [COL_W-1:0] col_pos_next;

    // stage 1: cell waiting for its line-store row
    logic                    s1_valid_reg;
    logic signed [VAL_W-1:0] s1_value_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_terminal_reg;
    logic                    s1_has_below_reg;
    logic                    s1_has_right_reg;
    logic                    s1_final_reg;

    // line store and its read port
    layer_vec_t line_mem [MAX_COLUMNS];
    layer_vec_t rd_data_reg;

    // bypass for a write to the row read in the same cycle (single-column grids)
    logic       fwd_hit_reg;
    layer_vec_t fwd_data_reg;

    layer_vec_t right_reg;
    layer_vec_t below;
    layer_vec_t nx;
    layer_vec_t fresh;

    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] best_total_reg;

    logic [CNT_W-1:0] rows_eff;
    logic [CMP_W-1:0] cols_eff;
    logic             last_col;
    logic             last_row;
    logic             advance;
    logic             accept;

    //------------------------------------------------------------------
    // Configuration port: always ready; write only while idle, as the block does not enforce that.
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CNT_W'(1);
            column_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // out-of-range counts: zero acts as one, large values clamp to the limit
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = CNT_W'(1);
        else if (row_count_reg > CNT_W'(ROW_LIMIT))
            rows_eff = CNT_W'(ROW_LIMIT);
        else
            rows_eff = row_count_reg;

        if (column_count_reg == '0)
            cols_eff = CMP_W'(1);
        else if (CMP_W'(column_count_reg) > CMP_W'(MAX_COLUMNS))
            cols_eff = CMP_W'(MAX_COLUMNS);
        else
            cols_eff = CMP_W'(column_count_reg);
    end

    assign last_col = (CMP_W'(col_pos_reg) + CMP_W'(1)) >= cols_eff;
    assign last_row = (CNT_W'(row_pos_reg) + CNT_W'(1)) >= rows_eff;

    //------------------------------------------------------------------
    // Handshake. Stage 1 retires whenever it holds a cell, unless it holds the
    // grid's last cell and the output register is occupied and not being read.
    //------------------------------------------------------------------
    assign advance  = s1_valid_reg && !(s1_final_reg && out_valid_reg && !out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // position counters step on every input transaction
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (last_col)
        begin
            col_pos_next = '0;
            if (last_row)
                row_pos_next = '0;
            else
                row_pos_next = row_pos_reg + ROW_W'(1);
        end
        else
        begin
            col_pos_next = col_pos_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    //------------------------------------------------------------------
    // Stage 1 capture
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            // the retiring cell writes the row this cell just read: bypass it
            if (accept)
                fwd_hit_reg <= s1_valid_reg && (s1_col_reg == col_pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg     <= cell_value;
            s1_col_reg       <= col_pos_reg;
            s1_terminal_reg  <= (row_pos_reg == '0) && (col_pos_reg == '0);
            s1_has_below_reg <= (row_pos_reg != '0);
            s1_has_right_reg <= (col_pos_reg != '0);
            s1_final_reg     <= last_col && last_row;
            fwd_data_reg     <= fresh;
        end
    end

    //------------------------------------------------------------------
    // Line store: one row per column, all layers side by side.
    // Read issued with the input transaction, written back at retire.
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
            line_mem[s1_col_reg] <= fresh;
        if (accept)
            rd_data_reg <= line_mem[col_pos_reg];
    end

    //------------------------------------------------------------------
    // Backward recurrence, one lane per budget layer
    //------------------------------------------------------------------
    for (genvar k = 0; k < BUDGET_LAYERS; k++)
    begin : g_layer
        logic signed [SUM_W:0] sum_w;
        logic                  take_prev;

        assign below[k] = fwd_hit_reg ? fwd_data_reg[k] : rd_data_reg[k];

        // better of the neighbors that exist
        assign nx[k] = (s1_has_below_reg && s1_has_right_reg)
                     ? (($signed(right_reg[k]) > $signed(below[k])) ? right_reg[k] : below[k])
                     : (s1_has_below_reg ? below[k] : right_reg[k]);

        assign sum_w = (SUM_W+1)'(s1_value_reg) + (SUM_W+1)'($signed(nx[k]));

        if (k > 0)
        begin : g_skip
            // neutralizing a negative cell spends one unit of budget
            assign take_prev = s1_value_reg[VAL_W-1]
                            && ((SUM_W+1)'($signed(nx[k-1])) > sum_w);
            assign fresh[k]  = s1_terminal_reg
                             ? (s1_value_reg[VAL_W-1] ? '0 : SUM_W'(s1_value_reg))
                             : (take_prev ? nx[k-1] : sum_w[SUM_W-1:0]);
        end
        else
        begin : g_base
            assign take_prev = 1'b0;
            assign fresh[k]  = (s1_terminal_reg || take_prev)
                             ? SUM_W'(s1_value_reg) : sum_w[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            right_reg <= '0;
        else if (advance)
            right_reg <= fresh;
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && s1_final_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_final_reg)
            best_total_reg <= $signed(fresh[BUDGET_LAYERS-1]);
    end

    assign out_valid  = out_valid_reg;
    assign best_total = best_total_reg;

endmodule

>>> rtl/gmps_checker.sv
`timescale 1ns / 1ps

module gmps_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [gmps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [gmps_pkg::CNT_W-1:0]          cfg_data,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic signed [gmps_pkg::VAL_W-1:0]   cell_value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [gmps_pkg::SUM_W-1:0]   best_total
);
    import gmps_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_total))
        else $error("best_total changed while stalled");

    // a fresh total follows the grid's last cell transaction through stage 1 and the output register
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a cell transaction two cycles earlier");

    // input backpressure only comes from a blocked output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low with output free");

    // configuration is never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind grid_max_path_sum_with_skips_unit gmps_checker u_gmps_checker (.*);

>>> verif/grid_max_path_sum_with_skips_unit_test.sv
`timescale 1ns / 1ps

module grid_max_path_sum_with_skips_unit_test;

    import gmps_pkg::*;

    // Stimulus stops once this many cells have gone in and enough random grids have ended
    localparam int CELL_TARGET  = 1750;
    localparam int MIN_GRIDS    = 40;
    // Watchdog: a slow correct run stays far below this
    localparam int CYCLE_LIMIT  = 1000000;
    // Cycles to wait after the last total before touching the counts
    localparam int SETTLE_CYCLES = 4;

    // Register indexes with no register behind them; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [VAL_W-1:0] cell_t;

    // How the cells of one grid are filled
    typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EXTREME, FILL_NEGATIVE} fill_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]  cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    cell_t             cell_value = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    sum_t              best_total;

    int failures        = 0;
    int cells_sent      = 0;
    int cycle_count     = 0;
    int hold_off_cycles = 0;   // set by a test, consumed by the result sink
    bit feed_steady     = 1'b0; // no gaps on the cell side
    bit sink_steady     = 1'b0; // out_ready held high

    // Totals predicted at cell acceptance, oldest first
    sum_t expected_totals[$];

    // ---------------------------------------------------------------------
    // Shadow copy of the path-sum state
    // ---------------------------------------------------------------------
    logic [CNT_W-1:0] grid_rows = CNT_W'(1);
    logic [CNT_W-1:0] grid_cols = CNT_W'(1);
    sum_t             line_best [BUDGET_LAYERS][MAX_COLUMNS];   // best sums of the row below
    sum_t             right_best [BUDGET_LAYERS] = '{default: '0};
    int unsigned      rows_done = 0;   // rows counted from the bottom
    int unsigned      cols_done = 0;   // columns counted from the right

    grid_max_path_sum_with_skips_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .best_total (best_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // A count of zero behaves as one, anything past the limit as the limit
    function automatic int unsigned clamp_count(logic [CNT_W-1:0] c, int unsigned limit);
        if (c == 0)
            return 1;
        if (c > limit)
            return limit;
        return c;
    endfunction

    // Backward recurrence for one cell. Layer k may have neutralized up to k negative
    // cells; a negative cell in layer k can also take layer k-1's best neighbor as-is.
    task automatic predict_cell(input cell_t cell_in);
        longint      val;
        longint      nx;
        longint      pr;
        longint      best;
        bit          neg;
        bit          has_below;
        bit          has_right;
        bit          have;
        bit          have_prev;
        int          k;
        sum_t        fresh [BUDGET_LAYERS];
        int unsigned nrows;
        int unsigned ncols;
        nrows     = clamp_count(grid_rows, ROW_LIMIT);
        ncols     = clamp_count(grid_cols, MAX_COLUMNS);
        val       = cell_in;
        neg       = (val < 0);
        has_below = (rows_done > 0);
        has_right = (cols_done > 0);
        for (k = 0; k < BUDGET_LAYERS; k++)
        begin
            if (!has_below && !has_right)
            begin
                // bottom-right cell: the path starts here
                best = (neg && k > 0) ? 0 : val;
            end
            else
            begin
                have = 1'b0;
                nx   = 0;
                if (has_below)
                begin
                    nx   = line_best[k][cols_done];
                    have = 1'b1;
                end
                if (has_right && (!have || right_best[k] > nx))
                    nx = right_best[k];
                best = val + nx;
                if (neg && k > 0)
                begin
                    have_prev = 1'b0;
                    pr        = 0;
                    if (has_below)
                    begin
                        pr        = line_best[k-1][cols_done];
                        have_prev = 1'b1;
                    end
                    if (has_right)
                    begin
                        if (!have_prev || right_best[k-1] > pr)
                            pr = right_best[k-1];
                        have_prev = 1'b1;
                    end
                    if (have_prev && pr > best)
                        best = pr;
                end
            end
            fresh[k] = best[SUM_W-1:0];   // 28-bit wrap
        end
        for (k = 0; k < BUDGET_LAYERS; k++)
        begin
            right_best[k]            = fresh[k];
            line_best[k][cols_done]  = fresh[k];
        end
        if (cols_done + 1 >= ncols)
        begin
            if (rows_done + 1 >= nrows)
            begin
                // top-left cell: the grid is done
                expected_totals.push_back(fresh[BUDGET_LAYERS-1]);
                rows_done = 0;
            end
            else
            begin
                rows_done++;
            end
            cols_done = 0;
        end
        else
        begin
            cols_done++;
        end
    endtask

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cell_t pick_cell(fill_t fill);
        case (fill)
            FILL_NARROW:   return VAL_W'(int'($urandom_range(0, 16)) - 8);
            FILL_NEGATIVE: return VAL_W'(-int'($urandom_range(1, 32768)));
            FILL_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            default:       return VAL_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Cell side. in_valid is left high after a transaction so that a
    // back-to-back cell never lowers and raises it in the same step.
    // ---------------------------------------------------------------------
    task automatic send_cell(input cell_t cell_in);
        int gap;
        gap = pick_gap(feed_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= cell_in;
        do @(posedge clk); while (!in_ready);
        predict_cell(cell_in);
        cells_sent++;
    endtask

    task automatic send_grid(input fill_t fill);
        int unsigned total;
        total = clamp_count(grid_rows, ROW_LIMIT) * clamp_count(grid_cols, MAX_COLUMNS);
        repeat (total) send_cell(pick_cell(fill));
    endtask

    // Stop offering cells and let every pending total come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // hold keeps cfg_valid up for a write that follows in the same step
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CNT_W-1:0] data, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ROW_COUNT:    grid_rows = data;
            CFG_COLUMN_COUNT: grid_cols = data;
            default: ;
        endcase
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_grid_size(input int rows, input int cols);
        wait_idle();
        write_register(CFG_ROW_COUNT, CNT_W'(rows), 1'b1);
        write_register(CFG_COLUMN_COUNT, CNT_W'(cols), 1'b0);
    endtask

    // ---------------------------------------------------------------------
    // Result side: out_ready pattern, plus the long hold-off on request
    // ---------------------------------------------------------------------
    initial
    begin : result_sink
        int idle;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                idle = hold_off_cycles;
                hold_off_cycles = 0;
                repeat (idle) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                idle = pick_gap(sink_steady);
                out_ready <= (idle == 0);
                if (idle > 1)
                    repeat (idle - 1) @(posedge clk);
            end
        end
    end

    // Every total transaction is matched against the oldest prediction
    always @(posedge clk)
    begin : total_checker
        sum_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("best_total: expected none, actual %0d", best_total);
                failures++;
            end
            else
            begin
                want = expected_totals.pop_front();
                if (best_total !== want)
                begin
                    $error("best_total: expected %0d, actual %0d", want, best_total);
                    failures++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // 1x1 grids after reset: the terminal cell alone, value extremes
    task automatic test_single_cells();
        send_cell(16'sh7FFF);
        send_cell(16'sh8000);
        send_cell(16'sh0000);
        send_cell(16'shFFFF);
        send_cell(16'sh0001);
    endtask

    // Paths with more negative cells than the budget covers, plus mixed ones
    task automatic test_skip_budget();
        set_grid_size(2, 2);
        repeat (4) send_cell(16'sh8000);
        send_cell(16'sh0005);
        send_cell(-16'sd3);
        send_cell(-16'sd7);
        send_cell(16'sh7FFF);
        set_grid_size(1, 3);
        send_cell(-16'sd1);
        send_cell(-16'sd2);
        send_cell(-16'sd3);
        set_grid_size(3, 1);
        repeat (3) send_cell(16'sh7FFF);
    endtask

    // Spare indexes, zero counts and counts past the limit; the largest shapes
    task automatic test_count_clamping();
        wait_idle();
        write_register(CFG_SPARE_2, '1, 1'b1);
        write_register(CFG_SPARE_3, '1, 1'b0);
        send_grid(FILL_WIDE);            // still 3x1 from before
        set_grid_size(0, 0);
        send_cell(-16'sd100);
        set_grid_size(1023, 1);          // tallest grid, rows clamp to the limit
        send_grid(FILL_WIDE);
        set_grid_size(1, 512);           // widest grid
        send_grid(FILL_NARROW);
        set_grid_size(3, 0);
        send_grid(FILL_NEGATIVE);
    endtask

    // Totals back up while the sink holds off; the block must stall cell transactions
    task automatic test_back_pressure();
        set_grid_size(1, 2);
        feed_steady = 1'b1;
        hold_off_cycles = 300;
        repeat (20) send_grid(FILL_WIDE);
        feed_steady = 1'b0;
    endtask

    // Random shapes and content, a few grids per setting
    task automatic test_random_grids();
        int grids;
        int rows;
        int cols;
        grids = 0;
        while (cells_sent < CELL_TARGET || grids < MIN_GRIDS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                rows = $urandom_range(1, 12);
                cols = $urandom_range(1, 12);
            end
            else
            begin
                rows = $urandom_range(1, 5);
                cols = $urandom_range(1, 5);
            end
            set_grid_size(rows, cols);
            feed_steady = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3))
            begin
                send_grid(fill_t'($urandom_range(0, 3)));
                grids++;
            end
        end
        feed_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin : run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_cells();
        test_skip_budget();
        test_count_clamping();
        test_back_pressure();
        test_random_grids();
        wait_idle();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
